[hw/rtl/capture_set_bit_analyzer_top_assert.svh]
// assertion macros for the capture set bit analyzer
`ifndef CAPTURE_SET_BIT_ANALYZER_TOP_ASSERT_SVH
`define CAPTURE_SET_BIT_ANALYZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CAB_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("check failed");
`define CAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CAB_ASSERT_ALWAYS(lbl, expr)
`define CAB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/cab_pkg.sv]
package cab_pkg;

    localparam int MAX_CAPTURES = 32;
    localparam int MAX_BITS     = 64;
    localparam int CAP_AW       = $clog2(MAX_CAPTURES);
    localparam int CNT_W        = $clog2(MAX_CAPTURES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [1:0] VERDICT_FIXED   = 2'd0;
    localparam logic [1:0] VERDICT_COUNTER = 2'd1;
    localparam logic [1:0] VERDICT_RANDOM  = 2'd2;
    localparam logic [1:0] VERDICT_MIXED   = 2'd3;

    localparam logic [1:0] PRED_NONE    = 2'd0;
    localparam logic [1:0] PRED_REPEAT  = 2'd1;
    localparam logic [1:0] PRED_COUNTER = 2'd2;

    typedef struct packed {
        logic load;
        logic shift;
    } bank_ctrl_t;

endpackage

[hw/rtl/capture_set_bit_analyzer_top.sv]
// capture set bit analyzer: each request on the slave side is one capture and is
// stored at its handshake (the block stays ready while a set is being loaded). a
// capture with tlast set ends the set: the per-position ones counters are walked one
// position a cycle through a single compare unit, then the stored captures are read
// back one per cycle from the capture memory to test for a rising counter field and
// a constant key step, and the finish state registers the result. the block takes
// no capture until that result is taken. captures beyond 32 in a set are dropped
// but still end the set when marked last.
module capture_set_bit_analyzer_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] capture_bits, [127:64] capture_key, [134:128] key_width, [135] zero
    input  logic [135:0] s_tdata,
    input  logic         s_tlast,       // last_capture
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] verdict, [8:2] fixed_bit_total, [15:9] changing_bit_total,
    // [22:16] span_low, [29:23] span_high, [31:30] prediction_kind,
    // [95:32] key_step, [159:96] predicted_key, [160] is_confident,
    // [168:161] set_size, [175:169] zero
    output logic [175:0] m_tdata
);

    `include "capture_set_bit_analyzer_top_assert.svh"

    localparam int CAP_AW = cab_pkg::CAP_AW;
    localparam int CNT_W  = cab_pkg::CNT_W;

    // input fields
    logic [63:0] in_bits, in_key;
    logic [6:0]  in_width;
    assign in_bits  = s_tdata[63:0];
    assign in_key   = s_tdata[127:64];
    assign in_width = s_tdata[134:128];

    cab_pkg::state_t state_reg, state_next;
    logic accept, out_take;
    assign accept   = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    // set bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic [6:0]       width_reg;
    logic             room;
    assign room = (count_reg < CNT_W'(cab_pkg::MAX_CAPTURES));

    // classify pass state
    logic [5:0] pos_reg;
    logic [6:0] fixed_reg, changing_reg, near_reg;
    logic [6:0] lo_reg, hi_reg;     // signed, -1 when no changing position

    // scan pass state
    logic [CAP_AW:0]   idx_reg;
    logic              rd_valid_reg;
    logic [CAP_AW-1:0] rd_pos_reg;
    logic [63:0]       prev_span_reg, prev_key_reg, step_reg, last_key_reg;
    logic              rise_ok_reg, step_ok_reg;

    // output register
    logic [175:0] out_reg;

    cab_pkg::bank_ctrl_t bank_ctrl;
    logic [7:0] head;
    logic [63:0] rd_bits, rd_key;
    logic issue;

    cab_ones_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bank_ctrl),
        .bits    (in_bits),
        .head    (head)
    );

    cab_capture_store u_store (
        .aclk    (aclk),
        .wr_en   (accept && room),
        .wr_addr (count_reg[CAP_AW-1:0]),
        .wr_bits (in_bits),
        .wr_key  (in_key),
        .rd_addr (idx_reg[CAP_AW-1:0]),
        .rd_bits (rd_bits),
        .rd_key  (rd_key)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cab_pkg::ST_IDLE: begin
                if (accept && s_tlast) state_next = cab_pkg::ST_CLASSIFY;
            end
            cab_pkg::ST_CLASSIFY: begin
                if (pos_reg == 6'd63) state_next = cab_pkg::ST_SCAN;
            end
            cab_pkg::ST_SCAN: begin
                if (rd_valid_reg && ({1'b0, rd_pos_reg} == CNT_W'(count_reg - 1'b1)))
                    state_next = cab_pkg::ST_FINISH;
            end
            cab_pkg::ST_FINISH: state_next = cab_pkg::ST_OUT;
            cab_pkg::ST_OUT: begin
                if (m_tready) state_next = cab_pkg::ST_IDLE;
            end
            default: state_next = cab_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        bank_ctrl.load  = 1'b0;
        bank_ctrl.shift = 1'b0;
        issue           = 1'b0;
        case (state_reg)
            cab_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                bank_ctrl.load = accept && room;
            end
            cab_pkg::ST_CLASSIFY: bank_ctrl.shift = 1'b1;
            cab_pkg::ST_SCAN: issue = ({1'b0, idx_reg} < (CNT_W + 1)'(count_reg));
            cab_pkg::ST_OUT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= cab_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // classification of the head counter
    logic [8:0] twice, dev;
    logic       in_width_rng, is_fixed, near_ok;
    always_comb begin
        twice        = {head, 1'b0};
        dev          = (twice >= 9'(count_reg)) ? twice - 9'(count_reg) : 9'(count_reg) - twice;
        in_width_rng = ({1'b0, pos_reg} < width_reg);
        is_fixed     = (head == 8'd0) || (head == 8'(count_reg));
        near_ok      = ({dev, 1'b0} <= 10'(count_reg));
    end

    // span field of the capture read back, msb-first from span_low up
    logic [63:0] rev_bits, span_val, wmask, key_m, key_diff;
    logic [5:0]  hi_u, lo_u;
    always_comb begin
        hi_u = hi_reg[5:0];
        lo_u = lo_reg[5:0];
        for (int p = 0; p < 64; p++) rev_bits[p] = rd_bits[63 - p];
        span_val = (rev_bits >> (6'd63 - hi_u)) & ({64{1'b1}} >> (6'd63 - (hi_u - lo_u)));
        wmask    = (width_reg >= 7'd64) ? {64{1'b1}} : ((64'd1 << width_reg[5:0]) - 64'd1);
        key_m    = rd_key & wmask;
        key_diff = key_m - prev_key_reg;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            width_reg    <= 7'd0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            case (state_reg)
                cab_pkg::ST_IDLE: begin
                    if (accept && room) begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == '0)
                            width_reg <= (in_width > 7'(cab_pkg::MAX_BITS)) ?
                                         7'(cab_pkg::MAX_BITS) : in_width;
                    end
                    pos_reg      <= 6'd0;
                    fixed_reg    <= 7'd0;
                    changing_reg <= 7'd0;
                    near_reg     <= 7'd0;
                    lo_reg       <= 7'h7f;
                    hi_reg       <= 7'h7f;
                    idx_reg      <= '0;
                end
                cab_pkg::ST_CLASSIFY: begin
                    pos_reg <= pos_reg + 6'd1;
                    if (in_width_rng) begin
                        if (is_fixed) begin
                            fixed_reg <= fixed_reg + 7'd1;
                        end else begin
                            changing_reg <= changing_reg + 7'd1;
                            if (lo_reg[6]) lo_reg <= {1'b0, pos_reg};
                            hi_reg <= {1'b0, pos_reg};
                            if (near_ok) near_reg <= near_reg + 7'd1;
                        end
                    end
                end
                cab_pkg::ST_SCAN: begin
                    if (issue) idx_reg <= idx_reg + 1'b1;
                    if (rd_valid_reg) begin
                        prev_span_reg <= span_val;
                        prev_key_reg  <= key_m;
                        last_key_reg  <= rd_key;
                        if (rd_pos_reg == '0) begin
                            rise_ok_reg <= 1'b1;
                            step_ok_reg <= 1'b0;
                        end else begin
                            if (span_val <= prev_span_reg) rise_ok_reg <= 1'b0;
                            if (rd_pos_reg == CAP_AW'(1)) begin
                                step_reg    <= key_diff;
                                step_ok_reg <= (key_diff != 64'd0);
                            end else if (key_diff != step_reg) begin
                                step_ok_reg <= 1'b0;
                            end
                        end
                    end
                end
                cab_pkg::ST_OUT: begin
                    if (m_tready) begin
                        count_reg <= '0;
                        width_reg <= 7'd0;
                    end
                end
                default: ;
            endcase
        end
        if (issue) rd_pos_reg <= idx_reg[CAP_AW-1:0];
    end

    // result formation
    logic [1:0]  verdict, kind;
    logic [63:0] step_out, pred_key;
    logic        confident;
    always_comb begin
        confident = (count_reg >= CNT_W'(3));
        if (changing_reg == 7'd0)
            verdict = cab_pkg::VERDICT_FIXED;
        else if (rise_ok_reg && confident)
            verdict = cab_pkg::VERDICT_COUNTER;
        else if (((hi_u - lo_u) >= 6'd7) && ({near_reg, 1'b0} >= {1'b0, changing_reg}))
            verdict = cab_pkg::VERDICT_RANDOM;
        else
            verdict = cab_pkg::VERDICT_MIXED;
        kind     = cab_pkg::PRED_NONE;
        step_out = 64'd0;
        pred_key = last_key_reg & wmask;
        if (changing_reg == 7'd0) begin
            kind = cab_pkg::PRED_REPEAT;
        end else if ((count_reg >= CNT_W'(2)) && step_ok_reg) begin
            kind     = cab_pkg::PRED_COUNTER;
            step_out = step_reg;
            pred_key = (last_key_reg + step_reg) & wmask;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cab_pkg::ST_FINISH)
            out_reg <= {7'd0, 8'(count_reg), confident, pred_key, step_out, kind,
                        hi_reg, lo_reg, changing_reg, fixed_reg, verdict};
    end

    assign m_tdata = out_reg;

    // checks
    `CAB_ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid))
    `CAB_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(cab_pkg::MAX_CAPTURES))
    `CAB_ASSERT_NEXT(a_clear_after_out, out_take, count_reg == '0)
    `CAB_ASSERT_NEXT(a_last_starts, accept && s_tlast, state_reg == cab_pkg::ST_CLASSIFY)

endmodule

[hw/rtl/cab_ones_bank.sv]
module cab_ones_bank (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cab_pkg::bank_ctrl_t           ctrl,
    input  logic [cab_pkg::MAX_BITS-1:0]  bits,
    output logic [7:0]                    head
);

    logic [7:0] cnt_reg [cab_pkg::MAX_BITS];

    // one counter per position; shifting toward position 0 also clears the bank
    always_ff @(posedge aclk) begin
        for (int p = 0; p < cab_pkg::MAX_BITS; p++) begin
            if (!aresetn) begin
                cnt_reg[p] <= 8'd0;
            end else if (ctrl.load) begin
                cnt_reg[p] <= cnt_reg[p] + {7'd0, bits[p]};
            end else if (ctrl.shift) begin
                cnt_reg[p] <= (p == cab_pkg::MAX_BITS - 1) ? 8'd0 : cnt_reg[(p + 1) % cab_pkg::MAX_BITS];
            end
        end
    end

    assign head = cnt_reg[0];

endmodule

[hw/rtl/cab_capture_store.sv]
module cab_capture_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [cab_pkg::CAP_AW-1:0]  wr_addr,
    input  logic [63:0]                 wr_bits,
    input  logic [63:0]                 wr_key,
    input  logic [cab_pkg::CAP_AW-1:0]  rd_addr,
    output logic [63:0]                 rd_bits,
    output logic [63:0]                 rd_key
);

    logic [63:0] bit_mem [cab_pkg::MAX_CAPTURES];
    logic [63:0] key_mem [cab_pkg::MAX_CAPTURES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bit_mem[wr_addr] <= wr_bits;
            key_mem[wr_addr] <= wr_key;
        end
        rd_bits <= bit_mem[rd_addr];
        rd_key  <= key_mem[rd_addr];
    end

endmodule

[verif/cab_result_checker.sv]
module cab_result_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [175:0] m_tdata,
    output int           fail_count,
    output int           result_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [6:0]  fixed_total;
        logic [6:0]  changing_total;
        logic [6:0]  span_lo;
        logic [6:0]  span_hi;
        logic [1:0]  kind;
        logic [63:0] step;
        logic [63:0] pred_key;
        logic        confident;
        logic [7:0]  set_size;
    } analysis_t;

    logic [63:0] cap_bits [cab_pkg::MAX_CAPTURES];
    logic [63:0] cap_keys [cab_pkg::MAX_CAPTURES];
    int          ones [cab_pkg::MAX_BITS];
    int          held;
    int          width_held;
    analysis_t   expected_analyses [$];

    function automatic logic [63:0] span_field(logic [63:0] b, int lo, int hi);
        logic [63:0] v;
        v = '0;
        for (int p = lo; p <= hi; p++) v = {v[62:0], b[p]};
        return v;
    endfunction

    function automatic analysis_t analyze_set();
        analysis_t   r;
        int          fixed_n, chg_n, near_n, lo, hi, dev;
        bit          rising, ok;
        logic [63:0] mask, d0;
        fixed_n = 0; chg_n = 0; near_n = 0; lo = -1; hi = -1;
        for (int p = 0; p < width_held; p++) begin
            if (ones[p] == 0 || ones[p] == held) begin
                fixed_n++;
            end else begin
                chg_n++;
                if (lo < 0) lo = p;
                hi = p;
                dev = 2 * ones[p] - held;
                if (dev < 0) dev = -dev;
                if (dev * 2 <= held) near_n++;
            end
        end
        rising = 0;
        if (chg_n > 0 && held >= 3) begin
            rising = 1;
            for (int i = 1; i < held; i++)
                if (span_field(cap_bits[i], lo, hi) <= span_field(cap_bits[i-1], lo, hi))
                    rising = 0;
        end
        if (chg_n == 0) r.verdict = cab_pkg::VERDICT_FIXED;
        else if (rising) r.verdict = cab_pkg::VERDICT_COUNTER;
        else if (hi - lo + 1 >= 8 && near_n * 2 >= chg_n) r.verdict = cab_pkg::VERDICT_RANDOM;
        else r.verdict = cab_pkg::VERDICT_MIXED;
        mask = (width_held >= 64) ? '1 : ((64'd1 << width_held) - 64'd1);
        r.kind = cab_pkg::PRED_NONE;
        r.step = '0;
        r.pred_key = cap_keys[held-1] & mask;
        if (chg_n == 0) begin
            r.kind = cab_pkg::PRED_REPEAT;
        end else if (held >= 2) begin
            d0 = (cap_keys[1] & mask) - (cap_keys[0] & mask);
            ok = (d0 != 0);
            for (int i = 2; i < held; i++)
                if (((cap_keys[i] & mask) - (cap_keys[i-1] & mask)) != d0) ok = 0;
            if (ok) begin
                r.kind = cab_pkg::PRED_COUNTER;
                r.step = d0;
                r.pred_key = (cap_keys[held-1] + d0) & mask;
            end
        end
        r.fixed_total = fixed_n[6:0];
        r.changing_total = chg_n[6:0];
        r.span_lo = lo[6:0];
        r.span_hi = hi[6:0];
        r.confident = (held >= 3);
        r.set_size = held[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            width_held = 0;
            for (int p = 0; p < cab_pkg::MAX_BITS; p++) ones[p] = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                analysis_t g, e;
                g.verdict = m_tdata[1:0];
                g.fixed_total = m_tdata[8:2];
                g.changing_total = m_tdata[15:9];
                g.span_lo = m_tdata[22:16];
                g.span_hi = m_tdata[29:23];
                g.kind = m_tdata[31:30];
                g.step = m_tdata[95:32];
                g.pred_key = m_tdata[159:96];
                g.confident = m_tdata[160];
                g.set_size = m_tdata[168:161];
                result_count++;
                if (expected_analyses.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    e = expected_analyses.pop_front();
                    if (g.verdict != e.verdict) report_mismatch("verdict", g.verdict, e.verdict);
                    if (g.fixed_total != e.fixed_total)
                        report_mismatch("fixed_bit_total", g.fixed_total, e.fixed_total);
                    if (g.changing_total != e.changing_total)
                        report_mismatch("changing_bit_total", g.changing_total,
                                        e.changing_total);
                    if (g.span_lo != e.span_lo) report_mismatch("span_low", g.span_lo, e.span_lo);
                    if (g.span_hi != e.span_hi) report_mismatch("span_high", g.span_hi, e.span_hi);
                    if (g.kind != e.kind) report_mismatch("prediction_kind", g.kind, e.kind);
                    if (g.step != e.step) report_mismatch("key_step", g.step, e.step);
                    if (g.pred_key != e.pred_key)
                        report_mismatch("predicted_key", g.pred_key, e.pred_key);
                    if (g.confident != e.confident)
                        report_mismatch("is_confident", g.confident, e.confident);
                    if (g.set_size != e.set_size)
                        report_mismatch("set_size", g.set_size, e.set_size);
                end
            end
            if (s_tvalid && s_tready) begin
                if (held < cab_pkg::MAX_CAPTURES) begin
                    if (held == 0)
                        width_held = (s_tdata[134:128] > cab_pkg::MAX_BITS) ?
                                     cab_pkg::MAX_BITS : s_tdata[134:128];
                    cap_bits[held] = s_tdata[63:0];
                    cap_keys[held] = s_tdata[127:64];
                    for (int p = 0; p < cab_pkg::MAX_BITS; p++) ones[p] = ones[p] + s_tdata[p];
                    held = held + 1;
                end
                if (s_tlast) begin
                    expected_analyses.push_back(analyze_set());
                    held = 0;
                    width_held = 0;
                    for (int p = 0; p < cab_pkg::MAX_BITS; p++) ones[p] = 0;
                end
            end
            pending_count = expected_analyses.size();
        end
    end
endmodule

[verif/tb_capture_set_bit_analyzer_top.sv]
module tb_capture_set_bit_analyzer_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;     // [63:0] capture_bits, [127:64] capture_key, [134:128] key_width
    logic         s_tlast;     // last_capture
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;     // verdict, totals, span, kind, step, key, confident, set_size
    int           fail_count, result_count, pending_count;

    int  send_idle_pct;        // chance in percent of a gap before a request
    int  recv_stall_pct;       // chance in percent of holding m_tready low
    bit  hold_off;             // long receiver hold-off, for back pressure
    int  sets_sent, captures_sent;

    capture_set_bit_analyzer_top uut (.*);

    cab_result_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .result_count, .pending_count
    );

    // 12 ns clock
    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    // receiver: random stalls, or a full hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one capture request; waits for the handshake, tvalid is left to the next request
    task automatic send_capture(logic [63:0] bits, logic [63:0] key, logic [6:0] kw,
                                logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, kw, key, bits};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        captures_sent++;
        if (last) sets_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // rising counter field with fixed surroundings, constant key step
    task automatic send_counter_set(int n, logic [6:0] kw);
        logic [63:0] base, key, step;
        int          lo, len;
        lo   = $urandom_range(0, 40);
        len  = $urandom_range(3, 20);
        base = rand64();
        key  = rand64();
        step = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(1, 9));
        for (int i = 0; i < n; i++) begin
            logic [63:0] b;
            b = base;
            for (int k = 0; k < len; k++) b[lo + k] = 1'(((i + 1) >> k) & 1);
            send_capture(b, key, kw, i == n - 1);
            key += step;
        end
    endtask

    // captures with random content, chosen shape
    task automatic send_random_set(int n, logic [6:0] kw, int style);
        logic [63:0] base, mask, key;
        base = rand64();
        mask = (style == 0) ? '1 : (rand64() & rand64());
        key  = rand64();
        for (int i = 0; i < n; i++) begin
            logic [63:0] b;
            b = (style == 2) ? base : ((base & ~mask) | (rand64() & mask));
            if ($urandom_range(3) != 0) key = rand64();
            send_capture(b, key, kw, i == n - 1);
        end
    endtask

    task automatic random_sets(int count);
        repeat (count) begin
            int          n, pick;
            logic [6:0]  kw;
            pick = $urandom_range(9);
            n    = ($urandom_range(15) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
            kw   = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
            if (pick < 4) send_counter_set(n < 3 ? 3 : n, kw);
            else send_random_set(n, kw, pick % 3);
        end
    endtask

    // stop offering, then wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // run limit
    initial begin
        #20ms;
        $display("tb_capture_set_bit_analyzer_top failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        hold_off = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sets_sent = 0;
        captures_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single capture, zero width, wide width, all zeros and ones
        send_capture('1, '1, 7'd64, 1'b1);
        send_capture('0, '0, 7'd0, 1'b1);
        send_capture(64'h0123, 64'h5, 7'd127, 1'b0);
        send_capture(64'h0f23, 64'h9, 7'd0, 1'b1);            // two captures, step key
        send_capture(64'h1, 64'h10, 7'd8, 1'b0);
        send_capture(64'h2, 64'h20, 7'd8, 1'b0);
        send_capture(64'h3, 64'h30, 7'd8, 1'b1);              // small counter
        send_capture(64'h8000_0000_0000_0000, '1, 7'd65, 1'b0);
        send_capture(64'h0, 64'h0, 7'd3, 1'b0);
        send_capture('1, 64'h1, 7'd3, 1'b1);                  // key wraps modulo 2^64
        // overflow: 34 captures, the last two dropped, and the last still ends the set
        for (int i = 0; i < 34; i++)
            send_capture(rand64(), 64'(i * 3), 7'd64, i == 33);
        drain();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 32 : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 32 : 0;
            random_sets(18);
            drain();
        end

        // long receiver hold-off while sets keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_sets(4);
        join
        drain();

        $display("sent %0d captures in %0d sets, %0d analyses checked",
                 captures_sent, sets_sent, result_count);
        $display("covered fixed, counter, random and mixed sets, overflow and width extremes");
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_capture_set_bit_analyzer_top passed");
        end else begin
            $display("tb_capture_set_bit_analyzer_top failed");
        end
        $finish;
    end
endmodule
